@@ hw/rtl/cma_pkg.sv @@
// ----------------------------------------------------------------------------
// Centered moving average: shared package
// Field widths, register reset value and the sequencer state type.
// ----------------------------------------------------------------------------
package cma_pkg;

  localparam int POS_W  = 32;   // position field, signed Q16.16
  localparam int SAMP_W = 32;   // sample field on the input port
  localparam int MEAN_W = 32;   // mean field, signed Q16.16
  localparam int HALF_W = 5;    // half_width register

  localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(2);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_ADD,
    ST_START,
    ST_DIV,
    ST_EMIT,
    ST_FLUSH,
    ST_DONE
  } seq_state_t;

endpackage

@@ hw/rtl/cma_if.sv @@
// ----------------------------------------------------------------------------
// Centered moving average: stream interfaces
// Row beats in, averaged or blank row beats out, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cma_in_if;
  import cma_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  position;
  logic signed [SAMP_W-1:0] sample;
  logic                     final_row;

  modport source (output valid, position, sample, final_row, input ready);
  modport sink   (input valid, position, sample, final_row, output ready);
endinterface

interface cma_out_if;
  import cma_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     row_valid;
  logic signed [POS_W-1:0]  position_out;
  logic signed [MEAN_W-1:0] mean;
  logic                     last_out;

  modport source (output valid, row_valid, position_out, mean, last_out, input ready);
  modport sink   (input valid, row_valid, position_out, mean, last_out, output ready);
endinterface

@@ hw/rtl/cma_ram.sv @@
// ----------------------------------------------------------------------------
// Centered moving average: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 33
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/cma_div.sv @@
// ----------------------------------------------------------------------------
// Centered moving average: serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cma_div #(
  parameter int N = 38,   // dividend and quotient width
  parameter int D = 6     // divisor width
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient
);

  localparam int CW = $clog2(N + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [D-1:0]  rem;
  logic [D-1:0]  dvs;
  logic [D:0]    rem_sh;
  logic [D:0]    rem_dif;
  logic          ge;

  assign rem_sh  = {rem, quotient[N-1]};
  assign rem_dif = rem_sh - {1'b0, dvs};
  assign ge      = (rem_sh >= {1'b0, dvs});

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(N);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: shift remainder, subtract divisor when it fits
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? rem_dif[D-1:0] : rem_sh[D-1:0];
      quotient <= {quotient[N-2:0], ge};
    end
  end

endmodule

@@ hw/rtl/centered_moving_average_unit.sv @@
// Sequencing: READ, UPDATE and ADD per accepted row, then START and DIV through
//   the serial divider if the window is full, EMIT for a beat, FLUSH, DONE.
// Flow: one row at a time; the next row is taken only back in IDLE, and EMIT and
//   FLUSH wait while the output beat is held by averages.ready.
// Reset: synchronous; clears the window sum, counters and half_width (to 2).
//   Ring contents are not cleared; read data is used only once written.
// ----------------------------------------------------------------------------
// Centered moving average unit
// Emits each row with the mean of the 2*half_width+1 samples centered on it.
// ----------------------------------------------------------------------------
module centered_moving_average_unit #(
  parameter int MAX_HALF_WIDTH = 16,
  parameter int SAMPLE_BITS    = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [cma_pkg::HALF_W-1:0] cfg_wdata,
  cma_in_if.sink                   rows,
  cma_out_if.source                averages
);
  import cma_pkg::*;

  // Ring holds the last window of rows; the sum needs log2(depth) guard bits.
  localparam int RING_DEPTH = 2 * MAX_HALF_WIDTH + 1;
  localparam int ADDR_W     = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int HW_BITS    = $clog2(MAX_HALF_WIDTH + 1);
  localparam int SUM_W      = SAMPLE_BITS + $clog2(RING_DEPTH);
  localparam int EXT_W      = SUM_W + MEAN_W;

  // Step a ring slot back by up to one full ring depth.
  function automatic logic [ADDR_W-1:0] slot_back(input logic [ADDR_W-1:0] slot,
                                                  input logic [CNT_W-1:0]  back);
    logic [CNT_W:0] t;
    t = (CNT_W+1)'(slot) + (CNT_W+1)'(RING_DEPTH) - (CNT_W+1)'(back);
    if (t >= (CNT_W+1)'(RING_DEPTH)) begin
      t = t - (CNT_W+1)'(RING_DEPTH);
    end
    return ADDR_W'(t);
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  seq_state_t               state, state_next;
  logic [HALF_W-1:0]        half_width;
  logic signed [SUM_W-1:0]  window_sum, window_sum_next;
  logic [CNT_W-1:0]         rows_seen, rows_seen_next;
  logic [ADDR_W-1:0]        write_slot, write_slot_next;
  logic [HW_BITS-1:0]       blank_cnt, blank_cnt_next;

  // Accepted row, held while the sequencer works on it.
  logic signed [SAMPLE_BITS-1:0] s_lat;
  logic [POS_W-1:0]              pos_lat;
  logic                          fin_lat;

  // Output register
  logic                     out_valid;
  logic                     out_row_valid;
  logic [POS_W-1:0]         out_pos;
  logic [MEAN_W-1:0]        out_mean;
  logic                     out_last;
  logic                     out_load;
  logic                     out_row_valid_next;
  logic [POS_W-1:0]         out_pos_next;
  logic [MEAN_W-1:0]        out_mean_next;
  logic                     out_last_next;

  // --------------------------------------------------------------------------
  // Window geometry: oversized half width clamps to the ring's limit.
  // --------------------------------------------------------------------------
  logic [HW_BITS-1:0] h_eff;
  logic [CNT_W-1:0]   h_cnt;
  logic [CNT_W-1:0]   two_h;
  logic [CNT_W-1:0]   w_len;
  logic               have_emit;   // row half_width back gets a result beat
  logic               have_full;   // that row has a complete window
  logic               sum_drop;    // oldest sample leaves the window

  assign h_eff = (32'(half_width) > MAX_HALF_WIDTH) ? HW_BITS'(MAX_HALF_WIDTH)
                                                    : HW_BITS'(half_width);
  assign h_cnt = CNT_W'(h_eff);
  assign two_h = CNT_W'({h_eff, 1'b0});
  assign w_len = CNT_W'({h_eff, 1'b1});

  assign have_emit = (rows_seen >= h_cnt);
  assign have_full = (rows_seen >= two_h);
  assign sum_drop  = (rows_seen >= w_len);

  // --------------------------------------------------------------------------
  // Sample taken as two's complement in SAMPLE_BITS bits
  // --------------------------------------------------------------------------
  logic [63:0]                   samp_zx;
  logic signed [SAMPLE_BITS-1:0] samp_in;

  assign samp_zx = {32'b0, rows.sample};
  assign samp_in = signed'(samp_zx[SAMPLE_BITS-1:0]);

  // --------------------------------------------------------------------------
  // Ring memories: one read per ring in READ, write of the new row in UPDATE.
  // --------------------------------------------------------------------------
  logic                          ring_rd_en;
  logic                          ring_wr_en;
  logic [SAMPLE_BITS-1:0]        samp_rd;
  logic [POS_W-1:0]              pos_rd;
  logic signed [SAMPLE_BITS-1:0] old_samp;

  cma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RING_DEPTH)
  ) u_sample_ring (
    .clk     (clk),
    .wr_en   (ring_wr_en),
    .wr_addr (write_slot),
    .wr_data (s_lat),
    .rd_en   (ring_rd_en),
    .rd_addr (slot_back(write_slot, w_len)),
    .rd_data (samp_rd)
  );

  cma_ram #(
    .WIDTH (POS_W),
    .DEPTH (RING_DEPTH)
  ) u_position_ring (
    .clk     (clk),
    .wr_en   (ring_wr_en),
    .wr_addr (write_slot),
    .wr_data (pos_lat),
    .rd_en   (ring_rd_en),
    .rd_addr (slot_back(write_slot, h_cnt)),
    .rd_data (pos_rd)
  );

  assign old_samp = signed'(samp_rd);

  // --------------------------------------------------------------------------
  // Shared divider: |window_sum| / window length, sign restored afterwards
  // so the quotient truncates toward zero.
  // --------------------------------------------------------------------------
  logic                    div_start;
  logic                    div_done;
  logic                    sum_neg;
  logic [SUM_W-1:0]        sum_mag;
  logic [SUM_W-1:0]        quo;
  logic signed [SUM_W-1:0] mean_full;
  logic [EXT_W-1:0]        mean_ext;

  assign sum_neg = window_sum[SUM_W-1];
  assign sum_mag = sum_neg ? unsigned'(-window_sum) : unsigned'(window_sum);

  cma_div #(
    .N (SUM_W),
    .D (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (w_len),
    .done     (div_done),
    .quotient (quo)
  );

  assign mean_full = sum_neg ? -signed'(quo) : signed'(quo);
  assign mean_ext  = unsigned'(EXT_W'(mean_full));

  // --------------------------------------------------------------------------
  // Sequencer: next state and datapath controls
  // --------------------------------------------------------------------------
  logic out_free;

  assign out_free   = !out_valid || averages.ready;
  assign rows.ready = (state == ST_IDLE);

  always_comb begin
    state_next         = state;
    window_sum_next    = window_sum;
    rows_seen_next     = rows_seen;
    write_slot_next    = write_slot;
    blank_cnt_next     = blank_cnt;
    ring_rd_en         = 1'b0;
    ring_wr_en         = 1'b0;
    div_start          = 1'b0;
    out_load           = 1'b0;
    out_row_valid_next = 1'b0;
    out_pos_next       = '0;
    out_mean_next      = '0;
    out_last_next      = 1'b0;

    case (state)
      ST_IDLE: begin
        if (rows.valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        // fetch the leaving sample and the centre row's position
        ring_rd_en = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        ring_wr_en = 1'b1;
        if (sum_drop) begin
          window_sum_next = window_sum - SUM_W'(old_samp);
        end
        state_next = ST_ADD;
      end
      ST_ADD: begin
        window_sum_next = window_sum + SUM_W'(s_lat);
        // blanks owed at the flush: half_width, or every row of a short stream
        blank_cnt_next  = have_emit ? h_eff : HW_BITS'(rows_seen + CNT_W'(1));
        if (have_emit) begin
          state_next = have_full ? ST_START : ST_EMIT;
        end else if (fin_lat) begin
          state_next = ST_FLUSH;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_START: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load           = 1'b1;
          out_row_valid_next = have_full;
          out_pos_next       = have_full ? ((h_eff == '0) ? pos_lat : pos_rd) : '0;
          out_mean_next      = have_full ? mean_ext[MEAN_W-1:0] : '0;
          out_last_next      = fin_lat && (h_eff == '0);
          state_next         = (fin_lat && blank_cnt != '0) ? ST_FLUSH : ST_DONE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_last_next  = (blank_cnt == HW_BITS'(1));
          blank_cnt_next = blank_cnt - HW_BITS'(1);
          if (blank_cnt == HW_BITS'(1)) begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        // advance the stream, or clear it after the final row
        if (fin_lat) begin
          window_sum_next = '0;
          rows_seen_next  = '0;
          write_slot_next = '0;
        end else begin
          rows_seen_next  = (rows_seen == w_len) ? w_len : rows_seen + CNT_W'(1);
          write_slot_next = (write_slot == ADDR_W'(RING_DEPTH - 1)) ? '0
                                                                   : write_slot + ADDR_W'(1);
        end
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control state; a register write restarts the stream.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      half_width <= HALF_RESET;
      window_sum <= '0;
      rows_seen  <= '0;
      write_slot <= '0;
      blank_cnt  <= '0;
      out_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      blank_cnt <= blank_cnt_next;
      if (cfg_we) begin
        half_width <= cfg_wdata;
        window_sum <= '0;
        rows_seen  <= '0;
        write_slot <= '0;
      end else begin
        window_sum <= window_sum_next;
        rows_seen  <= rows_seen_next;
        write_slot <= write_slot_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (averages.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: hold the accepted row and the pending result beat.
  always_ff @(posedge clk) begin
    if (rows.valid && rows.ready) begin
      s_lat   <= samp_in;
      pos_lat <= rows.position;
      fin_lat <= rows.final_row;
    end
    if (out_load) begin
      out_row_valid <= out_row_valid_next;
      out_pos       <= out_pos_next;
      out_mean      <= out_mean_next;
      out_last      <= out_last_next;
    end
  end

  assign averages.valid        = out_valid;
  assign averages.row_valid    = out_row_valid;
  assign averages.position_out = signed'(out_pos);
  assign averages.mean         = signed'(out_mean);
  assign averages.last_out     = out_last;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
  a_rows_sat: assert property (@(posedge clk) disable iff (rst)
    rows_seen <= w_len)
    else $error("rows_seen ran past the window length");

  a_blank_zero: assert property (@(posedge clk) disable iff (rst)
    averages.valid && !averages.row_valid |->
      averages.position_out == '0 && averages.mean == '0)
    else $error("blank row carries a nonzero payload");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide step");

  a_one_row: assert property (@(posedge clk) disable iff (rst)
    rows.valid && rows.ready |=> !rows.ready)
    else $error("second row taken while one is in work");
`endif

endmodule
